// File: rtl/gear_hash_chunker_core_assert.svh
// Assertion macros for the gear hash chunker checker.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef GEAR_HASH_CHUNKER_CORE_ASSERT_SVH
`define GEAR_HASH_CHUNKER_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define GHC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gear hash chunker check failed");

// Next-cycle implication, ignored while reset is asserted.
`define GHC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gear hash chunker check failed");

// Next-cycle implication that is also checked across reset.
`define GHC_ASSERT_NXT_ALL(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("gear hash chunker check failed");

`endif

// File: rtl/ghc_pkg.sv
// Shared types and constants for the gear hash chunker.
// No dependencies; used by every RTL file of the block but ghc_ram.
package ghc_pkg;

  // Stream offsets and chunk sizes.
  localparam int OFFSET_BITS = 48;
  // Gear table geometry.
  localparam int TABLE_ENTRIES = 256;
  localparam int TABLE_AW = 8;
  localparam int HASH_BITS = 64;
  localparam int SIZE_CFG_BITS = 32;

  typedef logic [OFFSET_BITS-1:0] ghc_ofs_t;
  typedef logic [HASH_BITS-1:0] ghc_hash_t;

  localparam ghc_ofs_t OFFSET_MAX = '1;

  // Request kinds on the input channel.
  localparam logic REQ_DATA  = 1'b0;
  localparam logic REQ_TABLE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CUT_MASK = 2'd0,
    CFG_MIN_SIZE = 2'd1,
    CFG_MAX_SIZE = 2'd2
  } ghc_cfg_idx_t;

  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 64;

  // Reset values of the configuration registers.
  localparam ghc_hash_t CUT_MASK_RST = 64'd8191;
  localparam logic [SIZE_CFG_BITS-1:0] MIN_SIZE_RST = 32'd2048;
  localparam logic [SIZE_CFG_BITS-1:0] MAX_SIZE_RST = 32'd65536;

  // One input transfer.
  typedef struct packed {
    logic            req_type;
    logic [7:0]      data_byte;
    logic            last_byte;
    logic [7:0]      table_index;
    logic [63:0]     table_word;
  } ghc_in_t;

  // One result transfer.
  typedef struct packed {
    ghc_ofs_t    chunk_start;
    ghc_ofs_t    chunk_end;
    logic        final_chunk;
  } ghc_out_t;

  // Configuration as seen by the cut logic.
  typedef struct packed {
    ghc_hash_t                cut_mask;
    logic [SIZE_CFG_BITS-1:0] min_size;
    logic [SIZE_CFG_BITS-1:0] max_size;
  } ghc_cfg_t;

  // Outcome of one data byte.
  typedef struct packed {
    logic     emit;
    ghc_out_t chunk;
  } ghc_res_t;

endpackage

// File: rtl/gear_hash_chunker_core.sv
// Gear hash content-defined chunker, top level.
// Depends on ghc_pkg, ghc_ram and ghc_cut_unit.
//
// Input channel (in_valid, in_stall, in_data): each transfer is either a
// gear table write or one data byte of the stream. Table writes go straight
// into the 256 x 64 gear table and produce no result. A data byte reads the
// table, updates the rolling hash and may produce one chunk result.
// Result channel (out_valid, out_stall, out_data): start and end offsets of
// a chunk, with final_chunk set on the chunk that closes the stream.
// Path: the table word is read into the RAM register when the byte
// transfers; the hash and cut decision load the output register once free.
// Throughput: one input transfer per cycle while not stalled, limited by
// the single table port, which serves one write or one read each cycle.
// Configuration (cfg_we, cfg_index, cfg_wdata) may be written only while
// the block is idle.
// Reset clears hash, offsets and handshake state and restores the default
// configuration; the gear table is not cleared and must be written first.
// A stalled result holds the output register; a byte waiting behind it
// raises in_stall until the result transfers.
module gear_hash_chunker_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ghc_pkg::ghc_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ghc_pkg::ghc_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [ghc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [ghc_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  ghc_pkg::ghc_cfg_t  cfg_r, cfg_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_last_r;
  logic               out_valid_r, out_valid_nxt;
  ghc_pkg::ghc_out_t  out_data_r;

  logic               in_accept;
  logic               out_free;
  logic               step;
  logic               tbl_we;
  logic               tbl_re;
  logic [ghc_pkg::TABLE_AW-1:0] tbl_addr;
  ghc_pkg::ghc_hash_t gear_word;
  ghc_pkg::ghc_res_t  res;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        ghc_pkg::CFG_CUT_MASK: cfg_nxt.cut_mask = cfg_wdata;
        ghc_pkg::CFG_MIN_SIZE: cfg_nxt.min_size = cfg_wdata[ghc_pkg::SIZE_CFG_BITS-1:0];
        ghc_pkg::CFG_MAX_SIZE: cfg_nxt.max_size = cfg_wdata[ghc_pkg::SIZE_CFG_BITS-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cut_mask <= ghc_pkg::CUT_MASK_RST;
      cfg_r.min_size <= ghc_pkg::MIN_SIZE_RST;
      cfg_r.max_size <= ghc_pkg::MAX_SIZE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Handshake: the byte stage moves on whenever the output register is free.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;
  assign step      = s1_valid_r && out_free;

  // Gear table port: a write for table transfers, a read for data bytes.
  assign tbl_we   = in_accept && (in_data.req_type == ghc_pkg::REQ_TABLE);
  assign tbl_re   = in_accept && (in_data.req_type == ghc_pkg::REQ_DATA);
  assign tbl_addr = (in_data.req_type == ghc_pkg::REQ_TABLE) ?
                    in_data.table_index : in_data.data_byte;

  ghc_ram #(
    .WIDTH (ghc_pkg::HASH_BITS),
    .DEPTH (ghc_pkg::TABLE_ENTRIES)
  ) u_gear_table (
    .clk   (clk),
    .we    (tbl_we),
    .re    (tbl_re),
    .addr  (tbl_addr),
    .wdata (in_data.table_word),
    .rdata (gear_word)
  );

  // Byte stage: one data byte waiting for its table word.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (tbl_re) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      s1_last_r <= in_data.last_byte;
    end
  end

  ghc_cut_unit u_cut (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .last      (s1_last_r),
    .gear_word (gear_word),
    .cfg       (cfg_r),
    .res       (res)
  );

  // Output register: loads a result, holds it while the receiver stalls.
  always_comb begin
    if (step && res.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.emit) begin
      out_data_r <= res.chunk;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/ghc_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module ghc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port share one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ghc_cut_unit.sv
// Rolling hash, stream offsets and boundary decision, one byte a cycle on step.
// Depends on ghc_pkg.
module ghc_cut_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                last,
  input  ghc_pkg::ghc_hash_t  gear_word,
  input  ghc_pkg::ghc_cfg_t   cfg,
  output ghc_pkg::ghc_res_t   res
);

  ghc_pkg::ghc_hash_t hash_r, hash_nxt;
  ghc_pkg::ghc_ofs_t  offset_r, offset_nxt;
  ghc_pkg::ghc_ofs_t  start_r, start_nxt;
  // Bytes in the open chunk so far, always offset_r - start_r.
  ghc_pkg::ghc_ofs_t  size_r, size_nxt;

  ghc_pkg::ghc_hash_t hash_upd;
  ghc_pkg::ghc_ofs_t  size_inc;
  ghc_pkg::ghc_ofs_t  end_ofs;
  ghc_pkg::ghc_ofs_t  min_ext;
  ghc_pkg::ghc_ofs_t  max_ext;
  logic               cut;

  // Hash update and saturating size and end offset.
  always_comb begin
    hash_upd = {hash_r[ghc_pkg::HASH_BITS-2:0], 1'b0} + gear_word;
    size_inc = (size_r == ghc_pkg::OFFSET_MAX) ? size_r : size_r + 1'b1;
    end_ofs  = (offset_r == ghc_pkg::OFFSET_MAX) ? offset_r : offset_r + 1'b1;
    min_ext  = ghc_pkg::ghc_ofs_t'(cfg.min_size);
    max_ext  = ghc_pkg::ghc_ofs_t'(cfg.max_size);
    cut      = (size_inc >= min_ext) &&
               ((size_inc >= max_ext) || ((hash_upd & cfg.cut_mask) == '0));
  end

  // Result of the byte: a cut, or the closing of the stream.
  always_comb begin
    res.emit              = cut || last;
    res.chunk.chunk_start = start_r;
    res.chunk.chunk_end   = end_ofs;
    res.chunk.final_chunk = last;
  end

  // Next state after the byte.
  always_comb begin
    hash_nxt   = hash_r;
    offset_nxt = offset_r;
    start_nxt  = start_r;
    size_nxt   = size_r;
    if (step) begin
      if (last) begin
        hash_nxt   = '0;
        offset_nxt = '0;
        start_nxt  = '0;
        size_nxt   = '0;
      end else if (cut) begin
        hash_nxt   = '0;
        offset_nxt = end_ofs;
        start_nxt  = end_ofs;
        size_nxt   = '0;
      end else begin
        hash_nxt   = hash_upd;
        offset_nxt = end_ofs;
        // The size only grows while the offset itself still grows.
        size_nxt   = (offset_r == ghc_pkg::OFFSET_MAX) ? size_r : size_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r   <= '0;
      offset_r <= '0;
      start_r  <= '0;
      size_r   <= '0;
    end else begin
      hash_r   <= hash_nxt;
      offset_r <= offset_nxt;
      start_r  <= start_nxt;
      size_r   <= size_nxt;
    end
  end

endmodule

// File: rtl/ghc_checker.sv
// Port-level checks for the gear hash chunker, bound to its top level.
// Depends on ghc_pkg and gear_hash_chunker_core_assert.svh.
`include "gear_hash_chunker_core_assert.svh"

module ghc_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input ghc_pkg::ghc_out_t                    out_data
);

  logic chunk_ordered;

  // A chunk never ends before it starts, and always ends past offset zero.
  assign chunk_ordered = (out_data.chunk_end >= out_data.chunk_start) &&
                         (out_data.chunk_end != '0);

  // No result survives a reset.
  `GHC_ASSERT_NXT_ALL(a_no_result_after_reset, !rst_n, !out_valid)

  // A stalled result stays presented and unchanged.
  `GHC_ASSERT_NXT(a_stall_holds, out_valid && out_stall, out_valid && $stable(out_data))

  // The input only stalls behind a result that the receiver holds off.
  `GHC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall)

  // Every presented chunk is well ordered.
  `GHC_ASSERT_IMP(a_chunk_order, out_valid, chunk_ordered)

endmodule

bind gear_hash_chunker_core ghc_checker u_ghc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: tb/tb_top.sv
// Self-checking testbench for the gear hash content-defined chunker.
// Depends on ghc_pkg and gear_hash_chunker_core; a directed table and
// random phases are checked against a chunk predictor written here.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 6;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 166;
  localparam int OFS_BITS = ghc_pkg::OFFSET_BITS;
  localparam logic [63:0] OFS_LIMIT = {{(64-OFS_BITS){1'b0}}, ghc_pkg::OFFSET_MAX};

  typedef enum logic {ROW_XFER, ROW_CFG} row_kind_t;

  // One row of the directed stimulus: a transfer or a register setting.
  typedef struct packed {
    row_kind_t          kind;
    ghc_pkg::ghc_in_t   item;
    logic               has_want;
    ghc_pkg::ghc_out_t  want;
    logic [63:0]        mask_v;
    logic [31:0]        min_v;
    logic [31:0]        max_v;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  ghc_pkg::ghc_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  ghc_pkg::ghc_out_t out_data;
  logic cfg_we = 1'b0;
  logic [ghc_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [ghc_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // Predictor state and its copy of the registers.
  logic [63:0] gear_tbl [ghc_pkg::TABLE_ENTRIES];
  logic [63:0] roll_hash = '0;
  logic [63:0] next_ofs = '0;
  logic [63:0] chunk_base = '0;
  logic [63:0] cut_mask = ghc_pkg::CUT_MASK_RST;
  logic [31:0] min_size = ghc_pkg::MIN_SIZE_RST;
  logic [31:0] max_size = ghc_pkg::MAX_SIZE_RST;

  ghc_pkg::ghc_out_t chunk_q [$];
  stim_row_t stim_rows [$];
  bit gaps_on = 1'b1;

  int n_items = 0;
  int n_bytes = 0;
  int n_tbl = 0;
  int n_chunks = 0;
  int n_final = 0;
  int n_fail = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  gear_hash_chunker_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Offsets and sizes stop at the top of the offset range.
  function automatic logic [63:0] sat_step(input logic [63:0] v);
    return (v >= OFS_LIMIT) ? OFS_LIMIT : v + 64'd1;
  endfunction

  // Applies one accepted transfer; returns 1 when it closes a chunk.
  function automatic bit chunk_predict(input ghc_pkg::ghc_in_t it,
                                       output ghc_pkg::ghc_out_t chunk);
    logic [63:0] size_v;
    logic [63:0] stop;
    bit cut;
    chunk = '0;
    if (it.req_type == ghc_pkg::REQ_TABLE) begin
      gear_tbl[it.table_index] = it.table_word;
      return 1'b0;
    end
    roll_hash = (roll_hash << 1) + gear_tbl[it.data_byte];
    size_v = sat_step(next_ofs - chunk_base);
    stop = sat_step(next_ofs);
    cut = (size_v >= {32'd0, min_size}) &&
          ((size_v >= {32'd0, max_size}) || ((roll_hash & cut_mask) == 64'd0));
    chunk.chunk_start = chunk_base[OFS_BITS-1:0];
    chunk.chunk_end = stop[OFS_BITS-1:0];
    chunk.final_chunk = it.last_byte;
    if (it.last_byte) begin
      roll_hash = '0;
      next_ofs = '0;
      chunk_base = '0;
      return 1'b1;
    end
    next_ofs = stop;
    if (cut) begin
      chunk_base = stop;
      roll_hash = '0;
    end
    return cut;
  endfunction

  function automatic ghc_pkg::ghc_in_t mk_byte(input logic [7:0] b, input logic last);
    ghc_pkg::ghc_in_t it;
    it.req_type = ghc_pkg::REQ_DATA;
    it.data_byte = b;
    it.last_byte = last;
    it.table_index = 8'($urandom_range(255));
    it.table_word = {$urandom, $urandom};
    return it;
  endfunction

  function automatic ghc_pkg::ghc_in_t mk_table(input logic [7:0] idx,
                                                input logic [63:0] w);
    ghc_pkg::ghc_in_t it;
    it.req_type = ghc_pkg::REQ_TABLE;
    it.data_byte = 8'($urandom_range(255));
    it.last_byte = 1'($urandom_range(1));
    it.table_index = idx;
    it.table_word = w;
    return it;
  endfunction

  function automatic void add_xfer(input ghc_pkg::ghc_in_t it, input logic has_want,
                                   input logic [47:0] start, input logic [47:0] stop,
                                   input logic fin);
    stim_row_t row;
    row = '0;
    row.kind = ROW_XFER;
    row.item = it;
    row.has_want = has_want;
    row.want.chunk_start = start;
    row.want.chunk_end = stop;
    row.want.final_chunk = fin;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [63:0] mask, input logic [31:0] min_v,
                                  input logic [31:0] max_v);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.mask_v = mask;
    row.min_v = min_v;
    row.max_v = max_v;
    stim_rows.push_back(row);
  endfunction

  // Drives one transfer from a falling edge and waits for it to be taken.
  task automatic send_item(input ghc_pkg::ghc_in_t it, input logic has_want,
                           input ghc_pkg::ghc_out_t want);
    ghc_pkg::ghc_out_t pred;
    bit emit;
    while (gaps_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    emit = chunk_predict(it, pred);
    if (has_want) chunk_q.push_back(want);
    else if (emit) chunk_q.push_back(pred);
    n_items++;
    if (it.req_type == ghc_pkg::REQ_TABLE) n_tbl++;
    else n_bytes++;
    @(negedge clk);
  endtask

  // Holds the sender until every chunk is out and the pipeline is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (chunk_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers; size writes carry random upper bits.
  task automatic write_config(input logic [63:0] mask, input logic [31:0] min_v,
                              input logic [31:0] max_v);
    cfg_we <= 1'b1;
    cfg_index <= ghc_pkg::CFG_CUT_MASK;
    cfg_wdata <= mask;
    @(negedge clk);
    cfg_index <= ghc_pkg::CFG_MIN_SIZE;
    cfg_wdata <= {$urandom, min_v};
    @(negedge clk);
    cfg_index <= ghc_pkg::CFG_MAX_SIZE;
    cfg_wdata <= {$urandom, max_v};
    @(negedge clk);
    cfg_we <= 1'b0;
    cut_mask = mask;
    min_size = min_v;
    max_size = max_v;
    n_cfg++;
  endtask

  // The receiver stalls at random unless idling is switched off.
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 31);
  end

  // Each result transfer is compared with the oldest expected chunk.
  always @(posedge clk) begin : chunk_check
    ghc_pkg::ghc_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (chunk_q.size() == 0) begin
        $display("%0t: unexpected chunk start %0d end %0d final %0b", $time,
                 out_data.chunk_start, out_data.chunk_end, out_data.final_chunk);
        n_fail++;
      end else begin
        want = chunk_q.pop_front();
        n_chunks++;
        if (want.final_chunk) n_final++;
        if (out_data !== want) begin
          $display("%0t: chunk mismatch: expected start %0d end %0d final %0b,",
                   $time, want.chunk_start, want.chunk_end, want.final_chunk);
          $display("%0t:   got start %0d end %0d final %0b",
                   $time, out_data.chunk_start, out_data.chunk_end,
                   out_data.final_chunk);
          n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel transfers.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] mask;
    logic [31:0] min_v;
    logic [31:0] max_v;
    ghc_pkg::ghc_in_t it;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: table extremes, reset limits, then the limit extremes.
    add_xfer(mk_table(8'h00, 64'd0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_table(8'hFF, '1), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_table(8'h5A, 64'hA5A5_A5A5_A5A5_A5A5), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_table(8'hA5, 64'h5A5A_5A5A_5A5A_5A5A), 1'b0, '0, '0, 1'b0);
    // A single-byte stream, then a three-byte stream, under the reset limits.
    add_xfer(mk_byte(8'h00, 1'b1), 1'b1, 48'd0, 48'd1, 1'b1);
    add_xfer(mk_byte(8'hFF, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'h5A, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'hFF, 1'b1), 1'b1, 48'd0, 48'd3, 1'b1);
    // Zero limits and zero mask: every byte cuts.
    add_cfg(64'd0, 32'd0, 32'd0);
    add_xfer(mk_byte(8'h00, 1'b0), 1'b1, 48'd0, 48'd1, 1'b0);
    add_xfer(mk_byte(8'hFF, 1'b0), 1'b1, 48'd1, 48'd2, 1'b0);
    add_xfer(mk_byte(8'h5A, 1'b1), 1'b1, 48'd2, 48'd3, 1'b1);
    // Largest limits and full mask: only the last byte closes a chunk.
    add_cfg('1, '1, '1);
    add_xfer(mk_byte(8'hFF, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'h00, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'hA5, 1'b1), 1'b1, 48'd0, 48'd3, 1'b1);
    // Maximum below minimum: a cut is forced as soon as the minimum is reached.
    add_cfg('1, 32'd2, 32'd0);
    add_xfer(mk_byte(8'h00, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'hFF, 1'b0), 1'b1, 48'd0, 48'd2, 1'b0);
    add_xfer(mk_byte(8'h5A, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'hA5, 1'b0), 1'b1, 48'd2, 48'd4, 1'b0);
    add_xfer(mk_byte(8'h00, 1'b1), 1'b1, 48'd4, 48'd5, 1'b1);
    // Content cuts on the low hash bit.
    add_cfg(64'd1, 32'd0, '1);
    add_xfer(mk_byte(8'h5A, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'h00, 1'b0), 1'b0, '0, '0, 1'b0);
    add_xfer(mk_byte(8'hFF, 1'b1), 1'b0, '0, '0, 1'b0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        drain_results();
        write_config(stim_rows[i].mask_v, stim_rows[i].min_v, stim_rows[i].max_v);
      end else begin
        send_item(stim_rows[i].item, stim_rows[i].has_want, stim_rows[i].want);
      end
    end

    // Fill the whole gear table before random bytes may read any entry.
    for (int idx = 0; idx < ghc_pkg::TABLE_ENTRIES; idx++) begin
      send_item(mk_table(idx[7:0], {$urandom, $urandom}), 1'b0, '0);
    end

    // Random phases, each under its own register setting.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      case (p)
        0: begin
          mask = '0;
          min_v = '0;
          max_v = '0;
        end
        1: begin
          mask = '1;
          min_v = '1;
          max_v = '1;
        end
        2: begin
          mask = {$urandom, $urandom};
          min_v = $urandom_range(6, 1);
          max_v = '0;
        end
        default: begin
          mask = '0;
          repeat ($urandom_range(3, 1)) mask[$urandom_range(63)] = 1'b1;
          min_v = $urandom_range(12);
          if ($urandom_range(3) == 0) max_v = $urandom_range(min_v);
          else max_v = min_v + $urandom_range(40, 1);
        end
      endcase
      write_config(mask, min_v, max_v);
      // One phase runs with no idling on either side.
      gaps_on = (p != 4);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // In phase 3 the sender holds off mid-phase until every chunk has come out.
        if (p == 3 && k == PHASE_ITEMS / 2) drain_results();
        if ($urandom_range(99) < 6) begin
          it = mk_table(8'($urandom_range(255)), {$urandom, $urandom});
        end else begin
          it = mk_byte(8'($urandom_range(255)), $urandom_range(23) == 0);
        end
        send_item(it, 1'b0, '0);
      end
    end

    gaps_on = 1'b1;
    drain_results();

    $display("Sent %0d transfers (%0d stream bytes, %0d table writes) under %0d settings.",
             n_items, n_bytes, n_tbl, n_cfg);
    $display("Checked %0d chunks, %0d of them closing a stream, with %0d mismatches.",
             n_chunks, n_final, n_fail);
    if (n_fail == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
